[hw/rtl/mhpq_pkg.sv]
// Package for the max-heap priority queue: sizes, operation and status codes,
// sequencer states and the heap memory request bundle. No dependencies.
`default_nettype none
package mhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int ENTRY_W  = 7;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // wide enough for child slots, the count and the request index
   localparam int IX_W     = (ADDR_W + 2 > ENTRY_W) ? ADDR_W + 2 : ENTRY_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_INCREASE = 2'd2,
      OP_PEEK     = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_BAD   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EX_RD,
      ST_INC_RD,
      ST_PK_RD,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_req_type;

endpackage
`default_nettype wire

[hw/rtl/mhpq_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule
`default_nettype wire

[hw/rtl/mhpq_engine.sv]
// Heap sequencer: decodes a request and walks sift-up / sift-down one level
// at a time, each level a read state and a compare/write state. Depends on mhpq_pkg.
`default_nettype none
module mhpq_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [mhpq_pkg::OP_W-1:0]    req_operation,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   req_key_value,
   input  wire logic [mhpq_pkg::INDEX_W-1:0] req_entry_index,
   output logic                              rsp_valid,
   output logic [mhpq_pkg::KEY_W-1:0]        rsp_result_value,
   output logic [mhpq_pkg::STAT_W-1:0]       rsp_status,
   output logic [mhpq_pkg::ENTRY_W-1:0]      rsp_entry_count,
   output mhpq_pkg::mem_req_type             mem_req,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   mem_rdata_a,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   mem_rdata_b
);

   localparam int ADDR_W  = mhpq_pkg::ADDR_W;
   localparam int CNT_W   = mhpq_pkg::CNT_W;
   localparam int IX_W    = mhpq_pkg::IX_W;
   localparam int KEY_W   = mhpq_pkg::KEY_W;
   localparam int ENTRY_W = mhpq_pkg::ENTRY_W;

   mhpq_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [KEY_W-1:0]     cur_ff, cur_in;
   logic [KEY_W-1:0]     value_ff, value_in;
   logic                 rsp_valid_ff;
   logic [KEY_W-1:0]     rsp_value_ff;
   mhpq_pkg::status_type rsp_status_ff;
   logic [mhpq_pkg::ENTRY_W-1:0] rsp_count_ff;

   logic                 done;
   logic [KEY_W-1:0]     done_value;
   mhpq_pkg::status_type done_status;

   logic                 accept;
   logic [IX_W-1:0]      count_x, left_x, right_x, index_x;
   logic [ADDR_W-1:0]    parent;
   logic                 right_ok;
   logic signed [KEY_W-1:0] key_cur, key_a, key_b, pick_key;
   logic [ADDR_W-1:0]    pick_addr;
   logic                 pick_moves;

   assign accept  = start && (state_ff == mhpq_pkg::ST_IDLE);
   assign busy    = (state_ff != mhpq_pkg::ST_IDLE);
   assign count_x = IX_W'(count_ff);
   assign index_x = IX_W'(req_entry_index);
   assign left_x  = (IX_W'(pos_ff) << 1) + IX_W'(1);
   assign right_x = left_x + IX_W'(1);
   assign parent  = (pos_ff - ADDR_W'(1)) >> 1;
   assign right_ok = right_x < count_x;
   assign key_cur = $signed(cur_ff);
   assign key_a   = $signed(mem_rdata_a);
   assign key_b   = $signed(mem_rdata_b);

   // child pick: left first, right only if strictly larger than the pick so far
   always_comb begin
      pick_key   = key_cur;
      pick_addr  = pos_ff;
      pick_moves = 1'b0;
      if (key_a > pick_key) begin
         pick_key   = key_a;
         pick_addr  = left_x[ADDR_W-1:0];
         pick_moves = 1'b1;
      end
      if (right_ok && (key_b > pick_key)) begin
         pick_key   = key_b;
         pick_addr  = right_x[ADDR_W-1:0];
         pick_moves = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      value_ff <= value_in;
      if (done) begin
         rsp_value_ff  <= done_value;
         rsp_status_ff <= done_status;
         rsp_count_ff  <= ENTRY_W'(count_in);
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      value_in    = value_ff;
      done        = 1'b0;
      done_value  = '0;
      done_status = mhpq_pkg::STAT_OK;
      mem_req     = '0;
      mem_req.wdata = cur_ff;
      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (mhpq_pkg::op_type'(req_operation))
                  mhpq_pkg::OP_INSERT: begin
                     if (count_ff >= CNT_W'(mhpq_pkg::CAPACITY)) begin
                        done        = 1'b1;
                        done_status = mhpq_pkg::STAT_FULL;
                     end else begin
                        cur_in   = req_key_value;
                        pos_in   = count_x[ADDR_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                        state_in = mhpq_pkg::ST_UP_RD;
                     end
                  end
                  mhpq_pkg::OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = mhpq_pkg::STAT_EMPTY;
                     end else begin
                        count_in        = count_ff - CNT_W'(1);
                        mem_req.raddr_a = '0;
                        mem_req.raddr_b = ADDR_W'(count_x - IX_W'(1));
                        state_in        = mhpq_pkg::ST_EX_RD;
                     end
                  end
                  mhpq_pkg::OP_INCREASE: begin
                     if (index_x >= count_x) begin
                        done        = 1'b1;
                        done_status = mhpq_pkg::STAT_BAD;
                     end else begin
                        cur_in          = req_key_value;
                        pos_in          = index_x[ADDR_W-1:0];
                        mem_req.raddr_a = index_x[ADDR_W-1:0];
                        state_in        = mhpq_pkg::ST_INC_RD;
                     end
                  end
                  mhpq_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = mhpq_pkg::STAT_EMPTY;
                     end else begin
                        mem_req.raddr_a = '0;
                        state_in        = mhpq_pkg::ST_PK_RD;
                     end
                  end
                  default: begin
                     state_in = mhpq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         mhpq_pkg::ST_EX_RD: begin
            value_in = mem_rdata_a;
            cur_in   = mem_rdata_b;
            pos_in   = '0;
            state_in = mhpq_pkg::ST_DN_RD;
         end
         mhpq_pkg::ST_INC_RD: begin
            if (key_cur < key_a) begin
               done        = 1'b1;
               done_status = mhpq_pkg::STAT_BAD;
               state_in    = mhpq_pkg::ST_IDLE;
            end else begin
               state_in = mhpq_pkg::ST_UP_RD;
            end
         end
         mhpq_pkg::ST_PK_RD: begin
            done       = 1'b1;
            done_value = mem_rdata_a;
            state_in   = mhpq_pkg::ST_IDLE;
         end
         mhpq_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               done          = 1'b1;
               state_in      = mhpq_pkg::ST_IDLE;
            end else begin
               mem_req.raddr_a = parent;
               state_in        = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (key_a >= key_cur) begin
               done     = 1'b1;
               state_in = mhpq_pkg::ST_IDLE;
            end else begin
               mem_req.wdata = mem_rdata_a;
               pos_in        = parent;
               state_in      = mhpq_pkg::ST_UP_RD;
            end
         end
         mhpq_pkg::ST_DN_RD: begin
            if (left_x >= count_x) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               done          = 1'b1;
               done_value    = value_ff;
               state_in      = mhpq_pkg::ST_IDLE;
            end else begin
               mem_req.raddr_a = left_x[ADDR_W-1:0];
               mem_req.raddr_b = right_x[ADDR_W-1:0];
               state_in        = mhpq_pkg::ST_DN_CMP;
            end
         end
         mhpq_pkg::ST_DN_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (!pick_moves) begin
               done       = 1'b1;
               done_value = value_ff;
               state_in   = mhpq_pkg::ST_IDLE;
            end else begin
               mem_req.wdata = pick_key;
               pos_in        = pick_addr;
               state_in      = mhpq_pkg::ST_DN_RD;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == mhpq_pkg::ST_IDLE))
      else $error("result beat while sequencer busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mhpq_pkg::CAPACITY))
      else $error("heap count above capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != mhpq_pkg::ST_IDLE) || rsp_valid_ff)
      else $error("accepted request neither started nor answered");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == mhpq_pkg::STAT_FULL))
         |-> (count_ff == CNT_W'(mhpq_pkg::CAPACITY)))
      else $error("full status with room left");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_req.we && (state_ff == mhpq_pkg::ST_UP_CMP)) |-> (pos_ff != '0))
      else $error("sift-up compare at the root");

endmodule
`default_nettype wire

[hw/rtl/max_heap_priority_queue_unit.sv]
// Max-heap priority queue top level: heap sequencer plus heap key RAM.
// Depends on mhpq_pkg, mhpq_ram and mhpq_engine.
//
// One request at a time: raise start with the request fields while busy is low.
// Each request produces exactly one result beat, rsp_valid high for one cycle;
// the receiver cannot stall it. Errors found at acceptance (full, empty, bad
// index) are answered straight from the idle state; a smaller key on increase
// and a peek are answered after one read of the heap RAM. Otherwise insert,
// increase and extract walk the heap, each level climbed or descended being one read
// and one compare/write, as the single heap RAM has registered read. busy is low
// while the result is out, so the next request may be taken at the same edge.
`default_nettype none
module max_heap_priority_queue_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [mhpq_pkg::OP_W-1:0]    req_operation,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   req_key_value,
   input  wire logic [mhpq_pkg::INDEX_W-1:0] req_entry_index,
   output logic                              rsp_valid,
   output logic [mhpq_pkg::KEY_W-1:0]        rsp_result_value,
   output logic [mhpq_pkg::STAT_W-1:0]       rsp_status,
   output logic [mhpq_pkg::ENTRY_W-1:0]      rsp_entry_count
);

   mhpq_pkg::mem_req_type          mem_req;
   logic [mhpq_pkg::KEY_W-1:0]     mem_rdata_a;
   logic [mhpq_pkg::KEY_W-1:0]     mem_rdata_b;

   mhpq_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key_value    (req_key_value),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .mem_req          (mem_req),
      .mem_rdata_a      (mem_rdata_a),
      .mem_rdata_b      (mem_rdata_b)
   );

   mhpq_ram #(
      .WIDTH (mhpq_pkg::KEY_W),
      .DEPTH (mhpq_pkg::CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .we      (mem_req.we),
      .waddr   (mem_req.waddr),
      .wdata   (mem_req.wdata),
      .raddr_a (mem_req.raddr_a),
      .raddr_b (mem_req.raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

endmodule
`default_nettype wire

[tb/mhpq_checker.sv]
// Scoreboard for the max-heap priority queue: keeps its own heap, predicts every
// result beat from the accepted request beats and compares field by field.
// Depends on mhpq_pkg.
module mhpq_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [mhpq_pkg::OP_W-1:0]    req_operation,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   req_key_value,
   input  wire logic [mhpq_pkg::INDEX_W-1:0] req_entry_index,
   input  wire logic                         rsp_valid,
   input  wire logic [mhpq_pkg::KEY_W-1:0]   rsp_result_value,
   input  wire logic [mhpq_pkg::STAT_W-1:0]  rsp_status,
   input  wire logic [mhpq_pkg::ENTRY_W-1:0] rsp_entry_count,
   output int                                fail_count,
   output int                                pending,
   output int                                held_keys
);
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;

   typedef struct {
      logic [KEY_W-1:0]   value;
      status_type         status;
      logic [ENTRY_W-1:0] count;
   } heap_answer_t;

   logic signed [KEY_W-1:0] heap_keys [CAPACITY];
   int unsigned             heap_size;
   heap_answer_t            expected_answers [$];
   int                      mismatches;

   initial begin
      fail_count = 0;
      pending    = 0;
      held_keys  = 0;
      mismatches = 0;
      heap_size  = 0;
   end

   task automatic swap_keys(input int unsigned a, input int unsigned b);
      logic signed [KEY_W-1:0] t;
      t            = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = t;
   endtask

   task automatic climb(input int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (heap_keys[parent] >= heap_keys[pos]) break;
         swap_keys(pos, parent);
         pos = parent;
      end
   endtask

   task automatic descend(input int unsigned pos);
      int unsigned left, right, pick;
      while (pos < heap_size) begin
         left  = 2 * pos + 1;
         right = 2 * pos + 2;
         pick  = pos;
         if (left < heap_size && heap_keys[left] > heap_keys[pos]) pick = left;
         if (right < heap_size && heap_keys[right] > heap_keys[pick]) pick = right;
         if (pick == pos) break;
         swap_keys(pos, pick);
         pos = pick;
      end
   endtask

   task automatic run_request(input op_type op, input logic signed [KEY_W-1:0] key,
                              input logic [INDEX_W-1:0] idx, output heap_answer_t ans);
      ans.value  = '0;
      ans.status = STAT_OK;
      case (op)
         OP_INSERT: begin
            if (heap_size >= CAPACITY) begin
               ans.status = STAT_FULL;
            end else begin
               heap_keys[heap_size] = key;
               heap_size++;
               climb(heap_size - 1);
            end
         end
         OP_EXTRACT: begin
            if (heap_size == 0) begin
               ans.status = STAT_EMPTY;
            end else begin
               ans.value = heap_keys[0];
               heap_size--;
               heap_keys[0] = heap_keys[heap_size];
               descend(0);
            end
         end
         OP_INCREASE: begin
            if (idx >= heap_size || key < heap_keys[idx]) begin
               ans.status = STAT_BAD;
            end else begin
               heap_keys[idx] = key;
               climb(idx);
            end
         end
         default: begin
            if (heap_size == 0) ans.status = STAT_EMPTY;
            else ans.value = heap_keys[0];
         end
      endcase
      ans.count = ENTRY_W'(heap_size);
   endtask

   always @(posedge clock) begin : watch
      heap_answer_t got;
      heap_answer_t want;
      if (reset) begin
         heap_size = 0;
         expected_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_result_value));
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            run_request(op_type'(req_operation), req_key_value, req_entry_index, got);
            expected_answers.push_back(got);
         end
      end
      fail_count <= mismatches;
      pending    <= expected_answers.size();
      held_keys  <= heap_size;
   end

endmodule

[tb/max_heap_priority_queue_unit_tb.sv]
// Testbench top for max_heap_priority_queue_unit: directed and phased random
// request traffic in bursts; checking is done by mhpq_checker. Depends on mhpq_pkg.
module max_heap_priority_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;

   localparam int PHASES     = 12;
   localparam int PHASE_LEN  = 150;
   localparam int STALL_MAX  = 3000;
   localparam int DRAIN_WAIT = 40;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_operation;
   logic [KEY_W-1:0]     req_key_value;
   logic [INDEX_W-1:0]   req_entry_index;
   logic                 rsp_valid;
   logic [KEY_W-1:0]     rsp_result_value;
   logic [STAT_W-1:0]    rsp_status;
   logic [ENTRY_W-1:0]   rsp_entry_count;
   int                   fail_count;
   int                   pending;
   int                   held_keys;
   int                   quiet_cycles;

   max_heap_priority_queue_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key_value    (req_key_value),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   mhpq_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key_value    (req_key_value),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .fail_count       (fail_count),
      .pending          (pending),
      .held_keys        (held_keys)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog: cycles with neither a request nor a result beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(input op_type op, input logic signed [KEY_W-1:0] key,
                        input logic [INDEX_W-1:0] idx);
      @(negedge clock);
      start           <= 1'b1;
      req_operation   <= op;
      req_key_value   <= key;
      req_entry_index <= idx;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      hold_off(1);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 16) - 8;
         1: begin
            case ($urandom_range(0, 5))
               0: return KEY_MAX;
               1: return KEY_MIN;
               2: return KEY_MAX - 1;
               3: return KEY_MIN + 1;
               4: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // phase kinds: 0 fills the heap, 1 drains it, 2 is an even mix
   function automatic op_type pick_op(input int kind);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (kind)
         0: return roll < 65 ? OP_INSERT : roll < 75 ? OP_EXTRACT :
                   roll < 90 ? OP_INCREASE : OP_PEEK;
         1: return roll < 10 ? OP_INSERT : roll < 75 ? OP_EXTRACT :
                   roll < 90 ? OP_INCREASE : OP_PEEK;
         default: return op_type'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      if (held_keys > 0 && $urandom_range(0, 4) != 0)
         return INDEX_W'($urandom_range(0, held_keys - 1));
      return INDEX_W'($urandom_range(0, CAPACITY - 1));
   endfunction

   initial begin
      int     burst;
      op_type op;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_INSERT;
      req_key_value   = '0;
      req_entry_index = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      issue(OP_PEEK, 0, 0);
      issue(OP_EXTRACT, 0, 0);
      issue(OP_INCREASE, KEY_MAX, 0);
      issue(OP_INSERT, 0, 0);
      issue(OP_INSERT, KEY_MAX, 0);
      issue(OP_INSERT, KEY_MIN, 0);
      issue(OP_INSERT, -1, 0);
      issue(OP_INSERT, 5, 0);
      issue(OP_INSERT, 5, 0);
      issue(OP_PEEK, 0, 0);
      issue(OP_INCREASE, KEY_MIN, 3);
      issue(OP_INCREASE, KEY_MAX, 63);
      issue(OP_INCREASE, KEY_MAX, 5);
      issue(OP_INCREASE, KEY_MIN, 1);
      repeat (7) issue(OP_EXTRACT, 0, 0);
      issue(OP_INSERT, 7, 0);
      issue(OP_INCREASE, 7, 0);
      issue(OP_INCREASE, 6, 0);
      issue(OP_EXTRACT, 0, 0);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         burst = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_LEN; n++) begin
            op = pick_op(phase % 3);
            issue(op, pick_key(), op == OP_INCREASE ? pick_index() : 6'($urandom));
            if (--burst == 0) begin
               if (phase % 4 != 1) hold_off($urandom_range(0, 12));
               burst = $urandom_range(1, 24);
            end
         end
         if (phase % 2 == 1) wait_drained();
      end

      wait_drained();
      hold_off(DRAIN_WAIT);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
